@@ rtl/dqvd_pkg.sv @@
// Shared constants for the deque with delete-by-value: field widths, operation and status codes.
package dqvd_pkg;

  localparam int DEPTH_DEF     = 64;
  localparam int WORD_BITS_DEF = 32;

  localparam int MODE_W   = 3;
  localparam int VALUE_W  = 32;
  localparam int COUNT_W  = 7;
  localparam int STATUS_W = 2;
  localparam int LENGTH_W = 7;

  localparam logic [MODE_W-1:0] MODE_ADD_FRONT = 3'd0;
  localparam logic [MODE_W-1:0] MODE_ADD_BACK  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_DEL_FRONT = 3'd2;
  localparam logic [MODE_W-1:0] MODE_DEL_BACK  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_DEL_VALUE = 3'd4;
  localparam logic [MODE_W-1:0] MODE_CLEAR     = 3'd5;
  localparam logic [MODE_W-1:0] MODE_PRINT     = 3'd6;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

endpackage

@@ rtl/dqvd_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
module dqvd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // Read data holds until the next read is issued.
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/deque_with_value_delete.sv @@
// Top level of the bounded deque of signed words with delete-by-value, clear and print.
//
// The entries live in one RAM of DEPTH words used as a ring; a front pointer and a fill
// count in flip-flops describe it. An operation is taken in the idle state and carried out
// in the execute state. A print or delete-by-value with entries to visit then walks the
// ring through the single RAM read port, one entry per cycle (a print only while the
// result channel is free), with the compaction writing survivors back through the write
// port behind the reads; every other operation finishes in the execute state once the
// output register is free. A new operation is accepted while the previous result still
// waits in the output register.
module deque_with_value_delete #(
  parameter int DEPTH     = dqvd_pkg::DEPTH_DEF,
  parameter int WORD_BITS = dqvd_pkg::WORD_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic        [dqvd_pkg::MODE_W-1:0]  mode,
  input  logic signed [dqvd_pkg::VALUE_W-1:0] value,
  input  logic        [dqvd_pkg::COUNT_W-1:0] count,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [dqvd_pkg::VALUE_W-1:0] item,
  output logic                                has_item,
  output logic       [dqvd_pkg::STATUS_W-1:0] status,
  output logic       [dqvd_pkg::LENGTH_W-1:0] length,
  output logic                                last
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int VW    = dqvd_pkg::VALUE_W;
  localparam int LW    = dqvd_pkg::LENGTH_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_RMV   = 3'd2;
  localparam logic [2:0] S_DONE  = 3'd3;
  localparam logic [2:0] S_PRINT = 3'd4;

  logic [2:0]                    state;
  logic [PTR_W-1:0]              front;
  logic [CNT_W-1:0]              fill;
  logic [dqvd_pkg::MODE_W-1:0]   cmd_mode;
  logic [WORD_BITS-1:0]          cmd_value;
  logic [dqvd_pkg::COUNT_W-1:0]  cmd_count;
  logic [CNT_W-1:0]              chk;
  logic [CNT_W-1:0]              keep;
  logic [CNT_W-1:0]              pidx;
  logic [CNT_W-1:0]              pn;

  logic                          ram_we;
  logic [PTR_W-1:0]              ram_waddr;
  logic [WORD_BITS-1:0]          ram_wdata;
  logic                          ram_re;
  logic [PTR_W-1:0]              ram_raddr;
  logic [WORD_BITS-1:0]          ram_rdata;

  logic                          out_free;
  logic                          full;
  logic                          empty;
  logic [PTR_W-1:0]              front_dec;
  logic [PTR_W-1:0]              front_inc;
  logic [CNT_W-1:0]              print_n;
  logic                          match;
  logic                          rmv_end;
  logic                          print_end;
  logic [CNT_W-1:0]              keep_new;

  // Ring position of the i-th entry counted from the front.
  function automatic logic [PTR_W-1:0] slot_of(input logic [PTR_W-1:0] f,
                                               input logic [CNT_W-1:0] i);
    logic [CNT_W:0] sum;
    sum = (CNT_W + 1)'(f) + (CNT_W + 1)'(i);
    if (sum >= (CNT_W + 1)'(DEPTH)) begin
      sum = sum - (CNT_W + 1)'(DEPTH);
    end
    return sum[PTR_W-1:0];
  endfunction

  assign out_free  = !out_valid || out_ready;
  assign full      = (fill == CNT_W'(DEPTH));
  assign empty     = (fill == '0);
  assign front_dec = (front == '0) ? PTR_W'(DEPTH - 1) : front - PTR_W'(1);
  assign front_inc = (front == PTR_W'(DEPTH - 1)) ? '0 : front + PTR_W'(1);
  assign print_n   = (cmd_count < LW'(fill)) ? CNT_W'(cmd_count) : fill;
  assign match     = (ram_rdata == cmd_value);
  assign rmv_end   = (CNT_W'(chk + CNT_W'(1)) == fill);
  assign print_end = (CNT_W'(pidx + CNT_W'(1)) == pn);
  assign keep_new  = match ? keep : CNT_W'(keep + CNT_W'(1));
  assign in_ready  = (state == S_IDLE);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = front;
    ram_wdata = cmd_value;
    ram_re    = 1'b0;
    ram_raddr = front;
    case (state)
      S_EXEC: begin
        case (cmd_mode)
          dqvd_pkg::MODE_ADD_FRONT: begin
            ram_we    = out_free && !full;
            ram_waddr = front_dec;
          end
          dqvd_pkg::MODE_ADD_BACK: begin
            ram_we    = out_free && !full;
            ram_waddr = slot_of(front, fill);
          end
          dqvd_pkg::MODE_DEL_VALUE: begin
            ram_re = !empty;
          end
          dqvd_pkg::MODE_PRINT: begin
            ram_re = (print_n != '0);
          end
          default: begin
          end
        endcase
      end
      S_RMV: begin
        // Survivors are written at or behind the entry just read, never ahead of reads.
        ram_we    = !match;
        ram_waddr = slot_of(front, keep);
        ram_wdata = ram_rdata;
        ram_re    = !rmv_end;
        ram_raddr = slot_of(front, CNT_W'(chk + CNT_W'(1)));
      end
      S_PRINT: begin
        ram_re    = out_free && !print_end;
        ram_raddr = slot_of(front, CNT_W'(pidx + CNT_W'(1)));
      end
      default: begin
      end
    endcase
  end

  dqvd_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      front     <= '0;
      fill      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            cmd_mode  <= mode;
            cmd_value <= WORD_BITS'(value);
            cmd_count <= count;
            state     <= S_EXEC;
          end
        end
        S_EXEC: begin
          if ((cmd_mode == dqvd_pkg::MODE_DEL_VALUE) && !empty) begin
            chk   <= '0;
            keep  <= '0;
            state <= S_RMV;
          end else if ((cmd_mode == dqvd_pkg::MODE_PRINT) && (print_n != '0)) begin
            pidx  <= '0;
            pn    <= print_n;
            state <= S_PRINT;
          end else if (out_free) begin
            out_valid <= 1'b1;
            item      <= '0;
            has_item  <= 1'b0;
            last      <= 1'b1;
            status    <= dqvd_pkg::STATUS_OK;
            length    <= LW'(fill);
            state     <= S_IDLE;
            case (cmd_mode)
              dqvd_pkg::MODE_ADD_FRONT: begin
                if (full) begin
                  status <= dqvd_pkg::STATUS_FULL;
                end else begin
                  front  <= front_dec;
                  fill   <= CNT_W'(fill + CNT_W'(1));
                  length <= LW'(fill + CNT_W'(1));
                end
              end
              dqvd_pkg::MODE_ADD_BACK: begin
                if (full) begin
                  status <= dqvd_pkg::STATUS_FULL;
                end else begin
                  fill   <= CNT_W'(fill + CNT_W'(1));
                  length <= LW'(fill + CNT_W'(1));
                end
              end
              dqvd_pkg::MODE_DEL_FRONT: begin
                if (empty) begin
                  status <= dqvd_pkg::STATUS_EMPTY;
                end else begin
                  front  <= front_inc;
                  fill   <= CNT_W'(fill - CNT_W'(1));
                  length <= LW'(fill - CNT_W'(1));
                end
              end
              dqvd_pkg::MODE_DEL_BACK: begin
                if (empty) begin
                  status <= dqvd_pkg::STATUS_EMPTY;
                end else begin
                  fill   <= CNT_W'(fill - CNT_W'(1));
                  length <= LW'(fill - CNT_W'(1));
                end
              end
              dqvd_pkg::MODE_DEL_VALUE: begin
                status <= dqvd_pkg::STATUS_EMPTY;
              end
              dqvd_pkg::MODE_CLEAR: begin
                front  <= '0;
                fill   <= '0;
                length <= '0;
              end
              default: begin
              end
            endcase
          end
        end
        S_RMV: begin
          keep <= keep_new;
          if (rmv_end) begin
            fill  <= keep_new;
            state <= S_DONE;
          end else begin
            chk <= CNT_W'(chk + CNT_W'(1));
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid <= 1'b1;
            item      <= '0;
            has_item  <= 1'b0;
            last      <= 1'b1;
            status    <= dqvd_pkg::STATUS_OK;
            length    <= LW'(fill);
            state     <= S_IDLE;
          end
        end
        S_PRINT: begin
          // Each transfer of a printed entry overlaps the read of the next one.
          if (out_free) begin
            out_valid <= 1'b1;
            item      <= VW'(signed'(ram_rdata));
            has_item  <= 1'b1;
            last      <= print_end;
            status    <= dqvd_pkg::STATUS_OK;
            length    <= LW'(fill);
            if (print_end) begin
              state <= S_IDLE;
            end else begin
              pidx <= CNT_W'(pidx + CNT_W'(1));
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CNT_W'(DEPTH))
    else $error("fill count exceeds capacity");

  a_keep_behind: assert property (@(posedge clk) disable iff (rst)
    (state == S_RMV) |-> (keep <= chk) && (chk < fill))
    else $error("compaction write pointer ran ahead of the read pointer");

  a_print_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == S_PRINT) |-> !ram_we && (pidx < pn))
    else $error("print walk wrote the store or overran its count");

  a_rmv_done_len: assert property (@(posedge clk) disable iff (rst)
    (state == S_RMV) && rmv_end |=> (state == S_DONE) && (fill <= $past(fill)))
    else $error("delete by value grew the store");

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for the deque with delete-by-value, clear and print.
`timescale 1ns / 1ps

module testbench;

  localparam int DEPTH    = dqvd_pkg::DEPTH_DEF;
  localparam int MODE_W   = dqvd_pkg::MODE_W;
  localparam int VALUE_W  = dqvd_pkg::VALUE_W;
  localparam int COUNT_W  = dqvd_pkg::COUNT_W;
  localparam int STATUS_W = dqvd_pkg::STATUS_W;
  localparam int LENGTH_W = dqvd_pkg::LENGTH_W;
  localparam logic [MODE_W-1:0] MODE_UNUSED = 3'd7;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic signed [VALUE_W-1:0] item;
    logic                      has_item;
    logic [STATUS_W-1:0]       status;
    logic [LENGTH_W-1:0]       length;
    logic                      last;
  } response_t;

  typedef struct packed {
    logic [MODE_W-1:0]         op;
    logic signed [VALUE_W-1:0] word;
    logic [COUNT_W-1:0]        n;
    logic                      typed;
    logic [STATUS_W-1:0]       exp_status;
    logic [LENGTH_W-1:0]       exp_length;
  } op_row_t;

  logic clk = 1'b0;
  logic rst;
  logic in_valid;
  logic in_ready;
  logic [MODE_W-1:0] mode;
  logic signed [VALUE_W-1:0] value;
  logic [COUNT_W-1:0] count;
  logic out_valid;
  logic out_ready;
  logic signed [VALUE_W-1:0] item;
  logic has_item;
  logic [STATUS_W-1:0] status;
  logic [LENGTH_W-1:0] length;
  logic last;

  logic signed [VALUE_W-1:0] shadow_deque[$];
  response_t dq_responses[$];
  response_t due;
  op_row_t dir_tab[25];
  int errors = 0;
  int send_idle = 9;
  int recv_idle = 55;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;

  deque_with_value_delete dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .mode(mode), .value(value), .count(count),
    .out_valid(out_valid), .out_ready(out_ready),
    .item(item), .has_item(has_item), .status(status), .length(length), .last(last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #20_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic op_row_t op_row(input logic [MODE_W-1:0] op,
                                     input logic signed [VALUE_W-1:0] word,
                                     input logic [COUNT_W-1:0] n, input logic typed,
                                     input logic [STATUS_W-1:0] st,
                                     input logic [LENGTH_W-1:0] len);
    op_row_t r;
    r.op = op;
    r.word = word;
    r.n = n;
    r.typed = typed;
    r.exp_status = st;
    r.exp_length = len;
    return r;
  endfunction

  // Applies one operation to the shadow deque and queues the responses it causes.
  task automatic apply_deque_op(input logic [MODE_W-1:0] op,
                                input logic signed [VALUE_W-1:0] word,
                                input logic [COUNT_W-1:0] n);
    logic signed [VALUE_W-1:0] kept[$];
    logic [STATUS_W-1:0] st;
    response_t r;
    int shown;
    st = dqvd_pkg::STATUS_OK;
    shown = 0;
    case (op)
      dqvd_pkg::MODE_ADD_FRONT: begin
        if (shadow_deque.size() >= DEPTH) st = dqvd_pkg::STATUS_FULL;
        else shadow_deque.push_front(word);
      end
      dqvd_pkg::MODE_ADD_BACK: begin
        if (shadow_deque.size() >= DEPTH) st = dqvd_pkg::STATUS_FULL;
        else shadow_deque.push_back(word);
      end
      dqvd_pkg::MODE_DEL_FRONT: begin
        if (shadow_deque.size() == 0) st = dqvd_pkg::STATUS_EMPTY;
        else void'(shadow_deque.pop_front());
      end
      dqvd_pkg::MODE_DEL_BACK: begin
        if (shadow_deque.size() == 0) st = dqvd_pkg::STATUS_EMPTY;
        else void'(shadow_deque.pop_back());
      end
      dqvd_pkg::MODE_DEL_VALUE: begin
        if (shadow_deque.size() == 0) begin
          st = dqvd_pkg::STATUS_EMPTY;
        end else begin
          foreach (shadow_deque[i]) begin
            if (shadow_deque[i] !== word) kept.push_back(shadow_deque[i]);
          end
          shadow_deque = kept;
        end
      end
      dqvd_pkg::MODE_CLEAR: shadow_deque.delete();
      dqvd_pkg::MODE_PRINT:
        shown = (int'(n) < shadow_deque.size()) ? int'(n) : shadow_deque.size();
      default: ;
    endcase
    r.length = LENGTH_W'(shadow_deque.size());
    if (shown > 0) begin
      for (int i = 0; i < shown; i++) begin
        r.item = shadow_deque[i];
        r.has_item = 1'b1;
        r.status = dqvd_pkg::STATUS_OK;
        r.last = (i == shown - 1);
        dq_responses.push_back(r);
      end
    end else begin
      r.item = '0;
      r.has_item = 1'b0;
      r.status = st;
      r.last = 1'b1;
      dq_responses.push_back(r);
    end
  endtask

  // Offers one operation, idling at random first, and predicts it on transfer.
  task automatic offer(input logic [MODE_W-1:0] op, input logic signed [VALUE_W-1:0] word,
                       input logic [COUNT_W-1:0] n);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    mode <= op;
    value <= word;
    count <= n;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    apply_deque_op(op, word, n);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (dq_responses.size() != 0) @(posedge clk);
  endtask

  // Mostly full-range words, with a small pool so delete-by-value finds repeats.
  function automatic logic signed [VALUE_W-1:0] pick_word();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) begin
      case ($urandom_range(0, 3))
        0: return 32'sh7FFF_FFFF;
        1: return 32'sh8000_0000;
        2: return 32'sh0;
        default: return -32'sd1;
      endcase
    end
    if (r < 40) return VALUE_W'($signed($urandom_range(0, 3)) - 2);
    return $urandom;
  endfunction

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] got_v);
    if (exp_v !== got_v) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, got_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (dq_responses.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual item %h status %0d",
                 $time, item, status);
        errors++;
      end else begin
        due = dq_responses.pop_front();
        check_field("item", due.item, item);
        check_field("has_item", 32'(due.has_item), 32'(has_item));
        check_field("status", 32'(due.status), 32'(status));
        check_field("length", 32'(due.length), 32'(length));
        check_field("last", 32'(due.last), 32'(last));
      end
    end
  end

  // Result side: random stalls, or one long hold-off when the stimulus asks for it.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = 1'b1;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle);
      end
    end
  end

  initial begin
    logic [MODE_W-1:0] op;
    logic signed [VALUE_W-1:0] word;
    logic [COUNT_W-1:0] n;
    response_t typed_r;
    int r;
    int burst;
    rst = 1'b1;
    in_valid = 1'b0;
    mode = dqvd_pkg::MODE_ADD_FRONT;
    value = '0;
    count = '0;
    dir_tab = '{
      op_row(dqvd_pkg::MODE_DEL_FRONT, 32'sh0, 7'd0, 1'b1, dqvd_pkg::STATUS_EMPTY, 7'd0),
      op_row(dqvd_pkg::MODE_DEL_BACK, 32'sh0, 7'd0, 1'b1, dqvd_pkg::STATUS_EMPTY, 7'd0),
      op_row(dqvd_pkg::MODE_DEL_VALUE, 32'sh5, 7'd0, 1'b1, dqvd_pkg::STATUS_EMPTY, 7'd0),
      op_row(dqvd_pkg::MODE_PRINT, 32'sh0, 7'd64, 1'b1, dqvd_pkg::STATUS_OK, 7'd0),
      op_row(dqvd_pkg::MODE_CLEAR, 32'sh0, 7'd0, 1'b1, dqvd_pkg::STATUS_OK, 7'd0),
      op_row(MODE_UNUSED, 32'sh0, 7'd127, 1'b1, dqvd_pkg::STATUS_OK, 7'd0),
      op_row(dqvd_pkg::MODE_ADD_BACK, 32'sh7FFF_FFFF, 7'd0, 1'b1, dqvd_pkg::STATUS_OK, 7'd1),
      op_row(dqvd_pkg::MODE_ADD_FRONT, 32'sh8000_0000, 7'd0, 1'b1, dqvd_pkg::STATUS_OK, 7'd2),
      op_row(dqvd_pkg::MODE_ADD_BACK, -32'sd1, 7'd0, 1'b1, dqvd_pkg::STATUS_OK, 7'd3),
      op_row(dqvd_pkg::MODE_ADD_FRONT, 32'sh0, 7'd0, 1'b1, dqvd_pkg::STATUS_OK, 7'd4),
      op_row(dqvd_pkg::MODE_ADD_BACK, -32'sd1, 7'd0, 1'b1, dqvd_pkg::STATUS_OK, 7'd5),
      op_row(dqvd_pkg::MODE_PRINT, 32'sh0, 7'd0, 1'b1, dqvd_pkg::STATUS_OK, 7'd5),
      op_row(dqvd_pkg::MODE_PRINT, 32'sh0, 7'd127, 1'b0, dqvd_pkg::STATUS_OK, 7'd0),
      op_row(dqvd_pkg::MODE_PRINT, 32'sh0, 7'd2, 1'b0, dqvd_pkg::STATUS_OK, 7'd0),
      op_row(dqvd_pkg::MODE_DEL_VALUE, -32'sd1, 7'd0, 1'b0, dqvd_pkg::STATUS_OK, 7'd0),
      op_row(dqvd_pkg::MODE_DEL_VALUE, 32'sd12345, 7'd0, 1'b1, dqvd_pkg::STATUS_OK, 7'd3),
      op_row(dqvd_pkg::MODE_PRINT, 32'sh0, 7'd64, 1'b0, dqvd_pkg::STATUS_OK, 7'd0),
      op_row(dqvd_pkg::MODE_DEL_FRONT, 32'sh0, 7'd0, 1'b1, dqvd_pkg::STATUS_OK, 7'd2),
      op_row(dqvd_pkg::MODE_DEL_FRONT, 32'sh0, 7'd0, 1'b1, dqvd_pkg::STATUS_OK, 7'd1),
      op_row(dqvd_pkg::MODE_DEL_BACK, 32'sh0, 7'd0, 1'b1, dqvd_pkg::STATUS_OK, 7'd0),
      op_row(dqvd_pkg::MODE_ADD_BACK, 32'sh5555_5555, 7'd0, 1'b1, dqvd_pkg::STATUS_OK, 7'd1),
      op_row(dqvd_pkg::MODE_ADD_FRONT, 32'sh2AAA_AAAA, 7'd0, 1'b1, dqvd_pkg::STATUS_OK, 7'd2),
      op_row(dqvd_pkg::MODE_CLEAR, 32'sh0, 7'd0, 1'b1, dqvd_pkg::STATUS_OK, 7'd0),
      op_row(dqvd_pkg::MODE_PRINT, 32'sh0, 7'd1, 1'b1, dqvd_pkg::STATUS_OK, 7'd0),
      op_row(dqvd_pkg::MODE_DEL_VALUE, 32'sh2AAA_AAAA, 7'd0, 1'b1,
             dqvd_pkg::STATUS_EMPTY, 7'd0)
    };
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Rows with a typed result replace the prediction, which still tracks the state.
    foreach (dir_tab[i]) begin
      offer(dir_tab[i].op, dir_tab[i].word, dir_tab[i].n);
      if (dir_tab[i].typed) begin
        typed_r.item = '0;
        typed_r.has_item = 1'b0;
        typed_r.status = dir_tab[i].exp_status;
        typed_r.length = dir_tab[i].exp_length;
        typed_r.last = 1'b1;
        dq_responses[dq_responses.size() - 1] = typed_r;
      end
    end
    drain();

    for (int ph = 0; ph < 3; ph++) begin
      send_idle = (ph == 0) ? 9 : (ph == 1) ? 55 : 0;
      recv_idle = (ph == 0) ? 55 : (ph == 1) ? 9 : 0;
      // The first fill runs against a long result stall so the input backs up.
      if (ph == 0) hold_req = 1'b1;
      burst = DEPTH - shadow_deque.size() + 2;
      for (int k = 0; k < burst; k++) begin
        op = $urandom_range(0, 1) ? dqvd_pkg::MODE_ADD_BACK : dqvd_pkg::MODE_ADD_FRONT;
        offer(op, pick_word(), COUNT_W'($urandom_range(0, 127)));
      end
      offer(dqvd_pkg::MODE_PRINT, pick_word(), COUNT_W'($urandom_range(64, 127)));
      for (int k = 0; k < 30; k++) begin
        r = $urandom_range(0, 99);
        word = pick_word();
        n = COUNT_W'($urandom_range(0, 127));
        if (r < 22) op = dqvd_pkg::MODE_ADD_FRONT;
        else if (r < 44) op = dqvd_pkg::MODE_ADD_BACK;
        else if (r < 56) op = dqvd_pkg::MODE_DEL_FRONT;
        else if (r < 68) op = dqvd_pkg::MODE_DEL_BACK;
        else if (r < 80) op = dqvd_pkg::MODE_DEL_VALUE;
        else if (r < 94) op = dqvd_pkg::MODE_PRINT;
        else if (r < 97) op = dqvd_pkg::MODE_CLEAR;
        else op = MODE_UNUSED;
        if (op == dqvd_pkg::MODE_DEL_VALUE && shadow_deque.size() > 0 &&
            $urandom_range(0, 3) != 0)
          word = shadow_deque[$urandom_range(0, shadow_deque.size() - 1)];
        if (op == dqvd_pkg::MODE_PRINT && $urandom_range(0, 9) < 7)
          n = COUNT_W'($urandom_range(0, 8));
        offer(op, word, n);
      end
      drain();
    end

    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/dqvd_pkg.sv
rtl/dqvd_ram.sv
rtl/deque_with_value_delete.sv
tb/testbench.sv
